[sv/rgbnv_pkg.sv]
// Shared types and constants of the RGB888 to NV12 converter.
// No dependencies; the other files but rgbnv_ram refer to this package.
package rgbnv_pkg;

  localparam int PIX_W = 8;       // one color component or plane byte
  localparam int POS_W = 12;      // row and column counters
  localparam int DIM_W = 13;      // dimension registers
  localparam int SUM_W = 9;       // sum of two components
  localparam int ACC_W = 16;      // weighted-sum accumulators
  localparam int DIM_LIMIT = 4096;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 13'd1920;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 13'd1080;
  localparam logic [DIM_W-1:0] DIM_MIN            = 13'd2;

  // BT.601 studio-swing weights.
  localparam logic [ACC_W-1:0] COEF_Y_R  = 16'd66;
  localparam logic [ACC_W-1:0] COEF_Y_G  = 16'd129;
  localparam logic [ACC_W-1:0] COEF_Y_B  = 16'd25;
  localparam logic [ACC_W-1:0] COEF_CB_R = 16'd38;
  localparam logic [ACC_W-1:0] COEF_CB_G = 16'd74;
  localparam logic [ACC_W-1:0] COEF_CB_B = 16'd112;
  localparam logic [ACC_W-1:0] COEF_CR_R = 16'd112;
  localparam logic [ACC_W-1:0] COEF_CR_G = 16'd94;
  localparam logic [ACC_W-1:0] COEF_CR_B = 16'd18;
  localparam logic [ACC_W-1:0] ROUND_HALF = 16'd128;
  // Rounding plus the +128 chroma offset folded in ahead of the shift.
  localparam logic [ACC_W-1:0] CHROMA_BIAS = 16'd32896;
  localparam logic [PIX_W-1:0] LUMA_OFFSET = 8'd16;

  // Result queue.
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;
  localparam int QUEUE_CNT_W = 4;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  // Line store word: blue high, red low.
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } pair_sum_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             has_chroma;
    logic             frame_last;
  } pos_meta_t;

  typedef struct packed {
    pos_meta_t        meta;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
  } result_entry_t;

  typedef enum logic {
    EMIT_LUMA,
    EMIT_CHROMA
  } emit_phase_t;

endpackage

[sv/rgbnv_if.sv]
// Stream interfaces of the converter: pixel input and result output.
// Depends on rgbnv_pkg for field widths.
interface rgbnv_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [rgbnv_pkg::PIX_W-1:0] red;
  logic [rgbnv_pkg::PIX_W-1:0] green;
  logic [rgbnv_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbnv_result_if;
  logic                        valid;
  logic                        ready;
  logic                        is_chroma;
  logic [rgbnv_pkg::POS_W-1:0] out_row;
  logic [rgbnv_pkg::POS_W-1:0] out_column;
  logic [rgbnv_pkg::PIX_W-1:0] luma;
  logic [rgbnv_pkg::PIX_W-1:0] chroma_blue;
  logic [rgbnv_pkg::PIX_W-1:0] chroma_red;
  logic                        run_last;
  logic                        frame_last;

  modport source (output valid, output is_chroma, output out_row, output out_column,
                  output luma, output chroma_blue, output chroma_red,
                  output run_last, output frame_last, input ready);
  modport sink (input valid, input is_chroma, input out_row, input out_column,
                input luma, input chroma_blue, input chroma_red,
                input run_last, input frame_last, output ready);
endinterface

[sv/rgbnv_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rgbnv_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 write_enable,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_address,
  input  logic [WIDTH-1:0]                     write_data,
  input  logic                                 read_enable,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_address,
  output logic [WIDTH-1:0]                     read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_address] <= write_data;
    end
    if (read_enable) begin
      read_data <= mem[read_address];
    end
  end

endmodule

[sv/rgbnv_color.sv]
// Color math pipeline: luma and 2x2 averaging in stage A, Cb/Cr in stage B.
// Depends on rgbnv_pkg.
module rgbnv_color (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  rgbnv_pkg::rgb_t          in_pixel,
  input  rgbnv_pkg::pair_sum_t     in_pair_sum,
  input  rgbnv_pkg::pos_meta_t     in_meta,
  input  rgbnv_pkg::pair_sum_t     line_entry,
  output logic [1:0]               pending,
  output logic                     out_valid,
  output rgbnv_pkg::result_entry_t out_entry
);

  logic [rgbnv_pkg::ACC_W-1:0] y_acc;
  logic [rgbnv_pkg::SUM_W:0]   total_r, total_g, total_b;
  logic [rgbnv_pkg::ACC_W-1:0] cb_acc, cr_acc;

  logic                        a_valid;
  logic [rgbnv_pkg::PIX_W-1:0] a_luma;
  rgbnv_pkg::rgb_t             a_avg;
  rgbnv_pkg::pos_meta_t        a_meta;

  // Stage A: luma of the current pixel, average of the 2x2 block.
  // Luma tops out at 235, so no clamp is needed.
  always_comb begin
    y_acc = rgbnv_pkg::COEF_Y_R * 16'(in_pixel.red)
          + rgbnv_pkg::COEF_Y_G * 16'(in_pixel.green)
          + rgbnv_pkg::COEF_Y_B * 16'(in_pixel.blue)
          + rgbnv_pkg::ROUND_HALF;
    total_r = {1'b0, in_pair_sum.red}   + {1'b0, line_entry.red};
    total_g = {1'b0, in_pair_sum.green} + {1'b0, line_entry.green};
    total_b = {1'b0, in_pair_sum.blue}  + {1'b0, line_entry.blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_luma      <= y_acc[15:8] + rgbnv_pkg::LUMA_OFFSET;
    a_avg.red   <= total_r[rgbnv_pkg::SUM_W:2];
    a_avg.green <= total_g[rgbnv_pkg::SUM_W:2];
    a_avg.blue  <= total_b[rgbnv_pkg::SUM_W:2];
    a_meta      <= in_meta;
  end

  // Stage B: true sums stay within 4336..61456, so modulo-2^16 math is exact
  // and the result byte (16..240) needs no clamp.
  always_comb begin
    cb_acc = rgbnv_pkg::CHROMA_BIAS
           + rgbnv_pkg::COEF_CB_B * 16'(a_avg.blue)
           - rgbnv_pkg::COEF_CB_R * 16'(a_avg.red)
           - rgbnv_pkg::COEF_CB_G * 16'(a_avg.green);
    cr_acc = rgbnv_pkg::CHROMA_BIAS
           + rgbnv_pkg::COEF_CR_R * 16'(a_avg.red)
           - rgbnv_pkg::COEF_CR_G * 16'(a_avg.green)
           - rgbnv_pkg::COEF_CR_B * 16'(a_avg.blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_entry.meta        <= a_meta;
    out_entry.luma        <= a_luma;
    out_entry.chroma_blue <= cb_acc[15:8];
    out_entry.chroma_red  <= cr_acc[15:8];
  end

  assign pending = {1'b0, a_valid} + {1'b0, out_valid};

endmodule

[sv/rgbnv_result_queue.sv]
// Result queue: one entry per pixel, unpacked into a luma and an optional
// chroma transaction on the result channel. Depends on rgbnv_pkg, rgbnv_if.
module rgbnv_result_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  rgbnv_pkg::result_entry_t            push_entry,
  output logic [rgbnv_pkg::QUEUE_CNT_W-1:0]   occupancy,
  rgbnv_result_if.source                      result
);

  rgbnv_pkg::result_entry_t             slots [rgbnv_pkg::QUEUE_DEPTH];
  rgbnv_pkg::result_entry_t             head_entry;
  logic [rgbnv_pkg::QUEUE_AW-1:0]       head, tail;
  rgbnv_pkg::emit_phase_t               phase, phase_next;
  logic                                 pop_item, pop_entry;

  assign head_entry = slots[head];
  assign pop_item   = result.valid && result.ready;
  assign pop_entry  = pop_item && (phase == rgbnv_pkg::EMIT_CHROMA ||
                                   !head_entry.meta.has_chroma);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      phase     <= rgbnv_pkg::EMIT_LUMA;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop_entry) begin
        head <= head + 1'b1;
      end
      occupancy <= occupancy + {{(rgbnv_pkg::QUEUE_CNT_W-1){1'b0}}, push}
                             - {{(rgbnv_pkg::QUEUE_CNT_W-1){1'b0}}, pop_entry};
      phase <= phase_next;
    end
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    case (phase)
      rgbnv_pkg::EMIT_LUMA: begin
        if (pop_item && head_entry.meta.has_chroma) begin
          phase_next = rgbnv_pkg::EMIT_CHROMA;
        end
      end
      rgbnv_pkg::EMIT_CHROMA: begin
        if (pop_item) begin
          phase_next = rgbnv_pkg::EMIT_LUMA;
        end
      end
      default: phase_next = rgbnv_pkg::EMIT_LUMA;
    endcase
  end

  // Outputs.
  always_comb begin
    result.valid       = (occupancy != '0);
    result.is_chroma   = 1'b0;
    result.out_row     = head_entry.meta.row;
    result.out_column  = head_entry.meta.column;
    result.luma        = head_entry.luma;
    result.chroma_blue = '0;
    result.chroma_red  = '0;
    result.run_last    = !head_entry.meta.has_chroma;
    result.frame_last  = !head_entry.meta.has_chroma && head_entry.meta.frame_last;
    case (phase)
      rgbnv_pkg::EMIT_LUMA: begin
      end
      rgbnv_pkg::EMIT_CHROMA: begin
        result.is_chroma   = 1'b1;
        result.out_row     = {1'b0, head_entry.meta.row[rgbnv_pkg::POS_W-1:1]};
        result.out_column  = {head_entry.meta.column[rgbnv_pkg::POS_W-1:1], 1'b0};
        result.luma        = '0;
        result.chroma_blue = head_entry.chroma_blue;
        result.chroma_red  = head_entry.chroma_red;
        result.run_last    = 1'b1;
        result.frame_last  = head_entry.meta.frame_last;
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/rgb_to_nv12_converter.sv]
// Top level of the RGB888 to NV12 (BT.601 studio swing) converter.
// Depends on rgbnv_pkg, rgbnv_if, rgbnv_ram, rgbnv_color, rgbnv_result_queue.
//
// Pixels come in raster order on the pixel channel, one per transaction.
// Each pixel gives a luma transaction; the odd pixel of an odd row also gives
// one Cb/Cr transaction (right after its luma) with the average of its 2x2
// block. Every result carries its plane row and column. Throughput: one pixel
// per clock on even rows unless the result queue fills; on odd rows the result
// channel carries three transactions per pixel pair, so the single result port
// holds the pixel rate below that. Each pixel passes the accept stage, color
// stages A and B and the result queue before its luma result. Even rows store
// the per-channel sum of each pixel pair in a MAX_WIDTH/2 x 27 line RAM; odd
// rows read it back. An entry is always read at least two pixels after it was
// written, so no forwarding path is needed. The line RAM has no clearing pass:
// every entry is written on the even row before the odd row reads it. Width
// and height are taken with bit 0 cleared, raised to 2 and capped at MAX_WIDTH
// (width, at most 4096) or 4096; write them only while no pixel is in flight.
module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rgbnv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rgbnv_pkg::DIM_W-1:0]         cfg_data,
  rgbnv_pixel_if.sink                         pixel,
  rgbnv_result_if.source                      result
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WIDTH_CAP  = (MAX_WIDTH > rgbnv_pkg::DIM_LIMIT) ?
                              rgbnv_pkg::DIM_LIMIT : MAX_WIDTH;

  // Configuration registers.
  logic [rgbnv_pkg::DIM_W-1:0] image_width, image_height;
  logic [rgbnv_pkg::DIM_W-1:0] width_even, height_even, width_eff, height_eff;

  // Position state.
  logic [rgbnv_pkg::POS_W-1:0] column_count, row_count;
  logic [rgbnv_pkg::POS_W-1:0] column_count_next, row_count_next;
  logic [rgbnv_pkg::DIM_W-1:0] column_inc, row_inc;
  logic                        col_wrap, row_wrap;
  rgbnv_pkg::rgb_t             left_pixel;
  rgbnv_pkg::rgb_t             in_pixel;
  rgbnv_pkg::pair_sum_t        pair_sum;

  // Line store addressing.
  logic [rgbnv_pkg::DIM_W-1:0] line_index_wide, line_index_mod;
  logic [LINE_AW-1:0]          line_addr;
  logic                        line_write, line_read;
  rgbnv_pkg::pair_sum_t        line_entry;

  // Accept stage registers.
  logic                        accept;
  logic                        s1_valid;
  rgbnv_pkg::rgb_t             s1_pixel;
  rgbnv_pkg::pair_sum_t        s1_pair_sum;
  rgbnv_pkg::pos_meta_t        s1_meta;

  logic [1:0]                        color_pending;
  logic                              color_valid;
  rgbnv_pkg::result_entry_t          color_entry;
  logic [rgbnv_pkg::QUEUE_CNT_W-1:0] occupancy;
  logic [rgbnv_pkg::QUEUE_CNT_W-1:0] committed;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rgbnv_pkg::IMAGE_WIDTH_RESET;
      image_height <= rgbnv_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbnv_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        rgbnv_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Effective frame size.
  always_comb begin
    width_even  = {image_width[rgbnv_pkg::DIM_W-1:1], 1'b0};
    height_even = {image_height[rgbnv_pkg::DIM_W-1:1], 1'b0};
    width_eff   = width_even;
    height_eff  = height_even;
    if (width_even < rgbnv_pkg::DIM_MIN) begin
      width_eff = rgbnv_pkg::DIM_MIN;
    end else if (width_even > rgbnv_pkg::DIM_W'(WIDTH_CAP)) begin
      width_eff = rgbnv_pkg::DIM_W'(WIDTH_CAP);
    end
    if (height_even < rgbnv_pkg::DIM_MIN) begin
      height_eff = rgbnv_pkg::DIM_MIN;
    end else if (height_even > rgbnv_pkg::DIM_W'(rgbnv_pkg::DIM_LIMIT)) begin
      height_eff = rgbnv_pkg::DIM_W'(rgbnv_pkg::DIM_LIMIT);
    end
  end

  // Credit check: every pixel in flight owns one queue entry.
  assign committed = occupancy
                   + {{(rgbnv_pkg::QUEUE_CNT_W-1){1'b0}}, s1_valid}
                   + {{(rgbnv_pkg::QUEUE_CNT_W-2){1'b0}}, color_pending};
  assign pixel.ready = (committed < rgbnv_pkg::QUEUE_CNT_W'(rgbnv_pkg::QUEUE_DEPTH));
  assign accept      = pixel.valid && pixel.ready;

  assign in_pixel.red   = pixel.red;
  assign in_pixel.green = pixel.green;
  assign in_pixel.blue  = pixel.blue;

  // Raster position; a pixel at or past the last column wraps the column.
  always_comb begin
    column_inc = {1'b0, column_count} + 13'd1;
    row_inc    = {1'b0, row_count} + 13'd1;
    col_wrap   = (column_inc >= width_eff);
    row_wrap   = col_wrap && (row_inc >= height_eff);
    column_count_next = col_wrap ? '0 : column_inc[rgbnv_pkg::POS_W-1:0];
    row_count_next    = row_count;
    if (col_wrap) begin
      row_count_next = row_wrap ? '0 : row_inc[rgbnv_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (!column_count[0]) begin
        left_pixel <= in_pixel;
      end
    end
  end

  assign pair_sum.red   = {1'b0, left_pixel.red}   + {1'b0, pixel.red};
  assign pair_sum.green = {1'b0, left_pixel.green} + {1'b0, pixel.green};
  assign pair_sum.blue  = {1'b0, left_pixel.blue}  + {1'b0, pixel.blue};

  // Pair index; the column stays below MAX_WIDTH, so one subtract wraps it.
  always_comb begin
    line_index_wide = {2'b00, column_count[rgbnv_pkg::POS_W-1:1]};
    line_index_mod  = line_index_wide;
    if (line_index_wide >= rgbnv_pkg::DIM_W'(LINE_DEPTH)) begin
      line_index_mod = line_index_wide - rgbnv_pkg::DIM_W'(LINE_DEPTH);
    end
  end
  assign line_addr  = line_index_mod[LINE_AW-1:0];
  assign line_write = accept && column_count[0] && !row_count[0];
  assign line_read  = accept && column_count[0] && row_count[0];

  rgbnv_ram #(
    .WIDTH ($bits(rgbnv_pkg::pair_sum_t)),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk           (clk),
    .write_enable  (line_write),
    .write_address (line_addr),
    .write_data    (pair_sum),
    .read_enable   (line_read),
    .read_address  (line_addr),
    .read_data     (line_entry)
  );

  // Accept stage; line RAM read data arrives in the same cycle as its registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pixel           <= in_pixel;
      s1_pair_sum        <= pair_sum;
      s1_meta.row        <= row_count;
      s1_meta.column     <= column_count;
      s1_meta.has_chroma <= column_count[0] && row_count[0];
      s1_meta.frame_last <= row_wrap;
    end
  end

  rgbnv_color u_color (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s1_valid),
    .in_pixel    (s1_pixel),
    .in_pair_sum (s1_pair_sum),
    .in_meta     (s1_meta),
    .line_entry  (line_entry),
    .pending     (color_pending),
    .out_valid   (color_valid),
    .out_entry   (color_entry)
  );

  rgbnv_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (color_valid),
    .push_entry (color_entry),
    .occupancy  (occupancy),
    .result     (result)
  );

endmodule

[sv/rgbnv_checker.sv]
// Port-level checks on the result channel of the converter, bound to the top.
// Depends on rgbnv_pkg and on the top level rgb_to_nv12_converter.
module rgbnv_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic                        is_chroma,
  input logic [rgbnv_pkg::POS_W-1:0] out_row,
  input logic [rgbnv_pkg::POS_W-1:0] out_column,
  input logic [rgbnv_pkg::PIX_W-1:0] luma,
  input logic [rgbnv_pkg::PIX_W-1:0] chroma_blue,
  input logic [rgbnv_pkg::PIX_W-1:0] chroma_red,
  input logic                        run_last,
  input logic                        frame_last
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(is_chroma) && $stable(out_row) && $stable(out_column) &&
      $stable(luma) && $stable(chroma_blue) && $stable(chroma_red) &&
      $stable(run_last) && $stable(frame_last))
    else $error("result payload changed while stalled");

  a_chroma_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_chroma |-> luma == '0 && run_last && !out_column[0])
    else $error("malformed chroma transaction");

  a_luma_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_chroma |->
      chroma_blue == '0 && chroma_red == '0 && (!frame_last || run_last))
    else $error("malformed luma transaction");

  a_chroma_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !is_chroma && !run_last |=>
      result_valid && is_chroma)
    else $error("chroma transaction missing after its luma");

endmodule

bind rgb_to_nv12_converter rgbnv_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .is_chroma    (result.is_chroma),
  .out_row      (result.out_row),
  .out_column   (result.out_column),
  .luma         (result.luma),
  .chroma_blue  (result.chroma_blue),
  .chroma_red   (result.chroma_red),
  .run_last     (result.run_last),
  .frame_last   (result.frame_last)
);

[dv/rgb_to_nv12_converter_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_nv12_converter: directed pixels, then random frames.
// Depends on rgbnv_pkg, rgbnv_if and the converter RTL; needs no other files.
module rgb_to_nv12_converter_test;

  localparam int MAX_PIXELS    = 4096;           // MAX_WIDTH given to the dut
  localparam int LINE_ENTRIES  = MAX_PIXELS / 2; // one line store entry per pixel pair
  localparam int SETTLE_CYCLES = 8;              // wait after the expected queue empties
  localparam int PIXEL_TARGET  = 1450;
  localparam int WIDE_ROW      = 64;             // wider rows are never completed
  localparam int DIRECTED_ROWS = 25;
  localparam int FINAL_WAIT    = 100000;

  // Package constants used throughout the bench.
  localparam int CFG_INDEX_W = rgbnv_pkg::CFG_INDEX_W;
  localparam int DIM_W       = rgbnv_pkg::DIM_W;
  localparam int DIM_LIMIT   = rgbnv_pkg::DIM_LIMIT;
  localparam bit [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = rgbnv_pkg::CFG_IMAGE_WIDTH;
  localparam bit [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = rgbnv_pkg::CFG_IMAGE_HEIGHT;
  localparam bit [DIM_W-1:0]       IMAGE_WIDTH_RESET  = rgbnv_pkg::IMAGE_WIDTH_RESET;
  localparam bit [DIM_W-1:0]       IMAGE_HEIGHT_RESET = rgbnv_pkg::IMAGE_HEIGHT_RESET;

  // One result transaction as the memory writer sees it.
  typedef struct packed {
    bit        is_chroma;
    bit [11:0] row;
    bit [11:0] column;
    bit [7:0]  luma;
    bit [7:0]  cb;
    bit [7:0]  cr;
    bit        run_last;
    bit        frame_last;
  } nv12_item_t;

  // Directed stimulus: optional register write ahead of the pixel, the pixel,
  // and hand-typed Y (and Cb/Cr where the pixel closes a 2x2 block).
  typedef struct packed {
    bit                   cfg_en;
    bit [CFG_INDEX_W-1:0] cfg_idx;
    bit [DIM_W-1:0]       cfg_val;
    bit [7:0]             r;
    bit [7:0]             g;
    bit [7:0]             b;
    bit                   typed;
    bit [7:0]             y;
    bit [7:0]             cb;
    bit [7:0]             cr;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  rgbnv_pixel_if  pix ();
  rgbnv_result_if res ();

  rgb_to_nv12_converter #(.MAX_WIDTH(MAX_PIXELS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix),
    .result    (res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Converter shadow: registers, raster position, left pixel, pair-sum line.
  // ---------------------------------------------------------------------------
  bit [DIM_W-1:0] width_reg  = IMAGE_WIDTH_RESET;
  bit [DIM_W-1:0] height_reg = IMAGE_HEIGHT_RESET;
  int             grid_col   = 0;
  int             grid_row   = 0;
  bit [7:0]       left_r = '0, left_g = '0, left_b = '0;
  bit [8:0]       pair_r [LINE_ENTRIES];
  bit [8:0]       pair_g [LINE_ENTRIES];
  bit [8:0]       pair_b [LINE_ENTRIES];

  nv12_item_t nv12_expected [$];
  int         mismatch_count = 0;
  int         pixels_sent    = 0;

  function automatic bit [7:0] clamp_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Bit 0 dropped, then held to 2..cap.
  function automatic int eff_dim(bit [DIM_W-1:0] raw, int cap);
    int d;
    d = int'(raw) & 32'h1FFE;
    if (d < 2) d = 2;
    if (d > cap) d = cap;
    return d;
  endfunction

  // Works out the results of one pixel and advances the shadow.
  // Returns how many results the pixel causes (1 or 2).
  function automatic int predict_nv12(input bit [7:0] r, g, b,
                                      output nv12_item_t luma_item,
                                      output nv12_item_t chroma_item);
    int w, h, idx, ar, ag, ab, cbv, crv, n;
    bit [8:0] sr, sg, sb;
    bit row_wrap;
    w = eff_dim(width_reg, MAX_PIXELS);
    h = eff_dim(height_reg, DIM_LIMIT);
    n = 1;
    row_wrap = 1'b0;
    luma_item   = '0;
    chroma_item = '0;
    luma_item.row    = grid_row[11:0];
    luma_item.column = grid_col[11:0];
    luma_item.luma   = clamp_byte(((66 * int'(r) + 129 * int'(g) + 25 * int'(b) + 128) >>> 8)
                                  + 16);
    if (grid_col % 2 == 0) begin
      left_r = r;
      left_g = g;
      left_b = b;
    end else begin
      sr  = {1'b0, left_r} + r;
      sg  = {1'b0, left_g} + g;
      sb  = {1'b0, left_b} + b;
      idx = (grid_col >> 1) % LINE_ENTRIES;
      if (grid_row % 2 == 0) begin
        pair_r[idx] = sr;
        pair_g[idx] = sg;
        pair_b[idx] = sb;
      end else begin
        // 2x2 average, truncated per channel
        ar  = (int'(sr) + int'(pair_r[idx])) >> 2;
        ag  = (int'(sg) + int'(pair_g[idx])) >> 2;
        ab  = (int'(sb) + int'(pair_b[idx])) >> 2;
        cbv = (-38 * ar - 74 * ag + 112 * ab + 128 + 32768) >>> 8;
        crv = (112 * ar - 94 * ag - 18 * ab + 128 + 32768) >>> 8;
        chroma_item.is_chroma = 1'b1;
        chroma_item.row       = grid_row[12:1];
        chroma_item.column    = grid_col[11:0] & 12'hFFE;
        chroma_item.cb        = clamp_byte(cbv);
        chroma_item.cr        = clamp_byte(crv);
        n = 2;
      end
    end
    // counters keep running past a shrunk dimension; wrap after this pixel
    if (grid_col + 1 >= w) begin
      grid_col = 0;
      row_wrap = (grid_row + 1 >= h);
      grid_row = row_wrap ? 0 : ((grid_row + 1) & 32'hFFF);
    end else begin
      grid_col = (grid_col + 1) & 32'hFFF;
    end
    if (n == 2) begin
      chroma_item.run_last   = 1'b1;
      chroma_item.frame_last = row_wrap;
    end else begin
      luma_item.run_last   = 1'b1;
      luma_item.frame_last = row_wrap;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    nv12_item_t want;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (nv12_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d",
                                  res.out_row, res.out_column));
      end else begin
        want = nv12_expected.pop_front();
        check_field("is_chroma",   12'(res.is_chroma),   12'(want.is_chroma));
        check_field("out_row",     res.out_row,          want.row);
        check_field("out_column",  res.out_column,       want.column);
        check_field("luma",        12'(res.luma),        12'(want.luma));
        check_field("chroma_blue", 12'(res.chroma_blue), 12'(want.cb));
        check_field("chroma_red",  12'(res.chroma_red),  12'(want.cr));
        check_field("run_last",    12'(res.run_last),    12'(want.run_last));
        check_field("frame_last",  12'(res.frame_last),  12'(want.frame_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle lengths: picked from three ranges, the shortest most often and the longest rarely.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 2);
    if (sel < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure; steady stretches with ready held high.
  bit steady_rx = 1'b0;
  initial begin
    int hold;
    hold = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) steady_rx = !steady_rx;
      if (hold > 0) begin
        res.ready <= 1'b0;
        hold--;
      end else begin
        res.ready <= 1'b1;
        if (!steady_rx && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side
  // ---------------------------------------------------------------------------
  // Drives one pixel, waits for its transaction, queues the expected results.
  // Leaves valid high so back-to-back pixels need no second assignment.
  task automatic push_pixel(input bit [7:0] r, g, b, input bit typed,
                            input bit [7:0] ty, tcb, tcr);
    nv12_item_t luma_item, chroma_item;
    int n;
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (pix.ready !== 1'b1);
    n = predict_nv12(r, g, b, luma_item, chroma_item);
    if (typed) begin
      luma_item.luma = ty;
      chroma_item.cb = tcb;
      chroma_item.cr = tcr;
    end
    nv12_expected.push_back(luma_item);
    if (n == 2) nv12_expected.push_back(chroma_item);
    pixels_sent++;
  endtask

  task automatic idle_after(input bit steady);
    if (!steady && $urandom_range(0, 2) == 0) begin
      pix.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Every pixel yields a result, so an empty queue plus the pipeline
  // latency means nothing is in flight.
  task automatic quiesce();
    pix.valid <= 1'b0;
    while (nv12_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Always called after quiesce, so cfg_write never sees two updates in a step.
  task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [DIM_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic bit [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // Raw register values: odd and sub-minimum values included on purpose.
  function automatic bit [DIM_W-1:0] pick_width();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 13'($urandom_range(0, 33));
    if (sel < 85) return 13'($urandom_range(34, 300));
    if (sel < 95) return 13'($urandom);
    case ($urandom_range(0, 3))
      0:       return 13'd8191;
      1:       return 13'd4096;
      2:       return 13'd4097;
      default: return 13'd1;
    endcase
  endfunction

  function automatic bit [DIM_W-1:0] pick_height();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 13'($urandom_range(0, 9));
    if (sel < 90) return 13'($urandom_range(10, 40));
    return 13'($urandom);
  endfunction

  // Directed rows. Uniform 2x2 blocks give Cb/Cr that can be read off the
  // BT.601 weights directly: gray -> 128/128, red -> 90/240, blue -> 240/110,
  // green -> 54/34. Width changes happen on even rows only, so an odd row
  // never reads a pair-sum entry its frame has not written.
  stim_row_t directed [DIRECTED_ROWS] = '{
    // default 1920x1080 right after reset: black luma
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd0,   8'd0},
    // width 0 -> 2 while sitting at column 2: pixel past the last column wraps
    '{1'b1, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0,   8'd0},
    // height 1 -> 2 mid-frame: this odd row closes the frame
    '{1'b1, CFG_IMAGE_HEIGHT, 13'd1,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd128, 8'd128},
    // 2x2 frames: white, then red
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd128, 8'd128},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd90,  8'd240},
    // all-ones width (capped at 4096), cut back after one pair
    '{1'b1, CFG_IMAGE_WIDTH,  13'd8191, 8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd0,   8'd0},
    '{1'b1, CFG_IMAGE_WIDTH,  13'd3,    8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd0,   8'd0},
    // all-ones height (capped at 4096): blue block ends no frame
    '{1'b1, CFG_IMAGE_HEIGHT, 13'd8191, 8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd240, 8'd110},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd0,   8'd0},
    // height cut to 2 on row 3: frame ends after this row
    '{1'b1, CFG_IMAGE_HEIGHT, 13'd2,    8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd54,  8'd34},
    // 6x4 frame with mixed colors, left to the predictor
    '{1'b1, CFG_IMAGE_WIDTH,  13'd6,    8'd0,   8'd128, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b1, CFG_IMAGE_HEIGHT, 13'd4,    8'd255, 8'd127, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
    '{1'b0, CFG_IMAGE_WIDTH,  13'd0,    8'd170, 8'd85,  8'd240, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int count, w_now, waited;
    bit steady, stuck;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data  = '0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    for (int i = 0; i < LINE_ENTRIES; i++) begin
      pair_r[i] = '0;
      pair_g[i] = '0;
      pair_b[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed[i]) begin
      if (directed[i].cfg_en) begin
        quiesce();
        write_reg(directed[i].cfg_idx, directed[i].cfg_val);
      end
      push_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].typed,
                 directed[i].y, directed[i].cb, directed[i].cr);
      idle_after(1'b0);
    end

    // Random phases. Each may rewrite the height (any row) and the width
    // (even rows only), then streams a burst of pixels. Wide rows are never
    // finished: the burst stops one pixel short of the last column, and the
    // next phase then forces a narrow width so that the row wraps early.
    while (pixels_sent < PIXEL_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 4) begin
        quiesce();
        write_reg(CFG_IMAGE_HEIGHT, pick_height());
      end
      w_now = eff_dim(width_reg, MAX_PIXELS);
      stuck = (w_now > WIDE_ROW) && (grid_col >= w_now - 1);
      if (grid_row % 2 == 0 && (stuck || $urandom_range(0, 9) < 4)) begin
        quiesce();
        write_reg(CFG_IMAGE_WIDTH, stuck ? 13'($urandom_range(0, 33)) : pick_width());
      end
      w_now = eff_dim(width_reg, MAX_PIXELS);
      count = $urandom_range(1, 120);
      if (w_now > WIDE_ROW && grid_row % 2 == 0 && count > w_now - 1 - grid_col)
        count = w_now - 1 - grid_col;
      for (int k = 0; k < count; k++) begin
        push_pixel(rand_byte(), rand_byte(), rand_byte(), 1'b0, 8'd0, 8'd0, 8'd0);
        idle_after(steady);
      end
    end

    // drain, then give stray results time to show up
    pix.valid <= 1'b0;
    waited = 0;
    while (nv12_expected.size() != 0 && waited < FINAL_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (nv12_expected.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", nv12_expected.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
